// ===== hw/rtl/gfba_pkg.sv =====
// ----------------------------------------------------------------------------
// Grouped free block allocator package
// Shared constants, command codes, sequencer states and the group index
// reduction used by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

  localparam int DEF_GROUP_SIZE = 16;
  localparam int DEF_NUM_BLOCKS = 1024;

  localparam int BLK_W = 10;
  localparam int CNT_W = 11;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPILL,
    ST_REFILL,
    ST_HOLD
  } gfba_state_t;

  // Block number modulo the number of blocks, by restoring subtraction of
  // shifted copies of the divisor. Only the shifts that fit the block width
  // produce logic, so at most a handful of compare and subtract steps remain.
  function automatic logic [BLK_W-1:0] blk_mod(input logic [BLK_W-1:0] b, input int n);
    logic [BLK_W-1:0] r;
    r = b;
    for (int k = BLK_W - 1; k >= 0; k--) begin
      if (((n << k) < (1 << BLK_W)) && (int'(r) >= (n << k))) begin
        r = r - BLK_W'(n << k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/grouped_free_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Grouped free block allocator
// Allocates and frees block numbers through a grouped free list: an in-core
// stack of GROUP_SIZE entries backed by a link store that holds full groups.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-----------------------------------
//  in      | input     | in_valid/in_stall| in_command, in_block_in
//  out     | output    | out_valid/out_stall | out_block_out, out_status,
//          |           |                  | out_free_count
//
//  A plain push or pop reads the stack memory at the top in the cycle it is
//  accepted, then updates the stack and loads the result register. A free onto
//  a full stack or a pop of the bottom entry moves a whole group between the
//  stack memory and the link memory one word per cycle.
//  Reset clears the stack valid bits at once; there is no clearing pass, the
//  link store holds nothing defined until a group is spilled into it.
//  One transaction is in work at a time; a finished result waits in the
//  output register while the next input transaction is taken.
//
`default_nettype none

module grouped_free_block_allocator_top
  import gfba_pkg::*;
#(
  parameter int GROUP_SIZE = DEF_GROUP_SIZE,
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_command,
  input  wire logic [BLK_W-1:0] in_block_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [BLK_W-1:0] out_block_out,
  output logic                  out_status,
  output logic      [CNT_W-1:0] out_free_count
);

  localparam int TW  = $clog2(GROUP_SIZE);
  localparam int CW  = $clog2(GROUP_SIZE + 1);
  localparam int TOT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LS_DEPTH = NUM_BLOCKS * GROUP_SIZE;
  localparam int LS_AW = $clog2(LS_DEPTH);
  localparam logic [TW-1:0]    TOP_LAST = TW'(GROUP_SIZE - 1);
  localparam logic [CW-1:0]    CNT_END  = CW'(GROUP_SIZE);
  localparam logic [TOT_W-1:0] TOT_MAX  = TOT_W'(NUM_BLOCKS);

  gfba_state_t state_r, state_nxt;

  logic [TW-1:0]    top_r, top_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [BLK_W-1:0] grp_r, grp_nxt;
  logic             cmd_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] res_blk_r, res_blk_nxt;
  logic [BLK_W-1:0] hold_blk_r, hold_blk_nxt;
  logic             hold_status_r, hold_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0] out_blk_r, out_blk_nxt;
  logic             out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [GROUP_SIZE-1:0] fs_vld_r, fs_vld_nxt;
  logic             rd_vld_r;

  logic             in_accept;
  logic             slot_free;
  logic             fin;
  logic [BLK_W-1:0] fin_blk;
  logic             fin_status;
  logic [BLK_W-1:0] pop_blk;
  logic [CW-1:0]    cnt_m1;
  logic [31:0]      ls_base;
  logic [31:0]      ls_raddr_full;
  logic [31:0]      ls_waddr_full;
  logic [31:0]      total_ext;

  logic             fs_we;
  logic [TW-1:0]    fs_waddr;
  logic [BLK_W-1:0] fs_wdata;
  logic [TW-1:0]    fs_raddr;
  logic [BLK_W-1:0] fs_rdata;
  logic             ls_we;
  logic [BLK_W-1:0] ls_rdata;

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (GROUP_SIZE)
  ) u_stack_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (LS_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr_full[LS_AW-1:0]),
    .wdata (pop_blk),
    .raddr (ls_raddr_full[LS_AW-1:0]),
    .rdata (ls_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Entries never written since reset read as zero.
  assign pop_blk = rd_vld_r ? fs_rdata : '0;

  assign cnt_m1        = cnt_r - CW'(1);
  assign ls_base       = 32'(grp_r) * 32'(GROUP_SIZE);
  assign ls_raddr_full = ls_base + 32'(cnt_r);
  assign ls_waddr_full = ls_base + 32'(cnt_m1);
  assign total_ext     = 32'(total_nxt);

  always_comb begin
    state_nxt       = state_r;
    top_nxt         = top_r;
    total_nxt       = total_r;
    cnt_nxt         = cnt_r;
    grp_nxt         = grp_r;
    res_blk_nxt     = res_blk_r;
    hold_blk_nxt    = hold_blk_r;
    hold_status_nxt = hold_status_r;
    fs_vld_nxt      = fs_vld_r;
    fin             = 1'b0;
    fin_blk         = '0;
    fin_status      = STATUS_OK;
    fs_we           = 1'b0;
    fs_waddr        = '0;
    fs_wdata        = blk_r;
    fs_raddr        = top_r;
    ls_we           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (cmd_r == CMD_ALLOC) begin
          if (total_r == '0) begin
            fin        = 1'b1;
            fin_status = STATUS_FULL;
          end else if (top_r != '0) begin
            top_nxt   = top_r - TW'(1);
            total_nxt = total_r - TOT_W'(1);
            fin       = 1'b1;
            fin_blk   = pop_blk;
          end else begin
            // Bottom entry popped: its group reloads the whole stack.
            res_blk_nxt = pop_blk;
            grp_nxt     = blk_mod(pop_blk, NUM_BLOCKS);
            cnt_nxt     = '0;
            state_nxt   = ST_REFILL;
          end
        end else begin
          if (top_r != TOP_LAST) begin
            fs_we     = 1'b1;
            fs_waddr  = top_r + TW'(1);
            fs_vld_nxt[top_r + TW'(1)] = 1'b1;
            top_nxt   = top_r + TW'(1);
            if (total_r < TOT_MAX) begin
              total_nxt = total_r + TOT_W'(1);
            end
            fin = 1'b1;
          end else begin
            grp_nxt   = blk_mod(blk_r, NUM_BLOCKS);
            cnt_nxt   = '0;
            state_nxt = ST_SPILL;
          end
        end
      end

      ST_SPILL: begin
        // Read stack entry cnt, write the entry read last cycle to the group.
        fs_raddr = (cnt_r < CNT_END) ? cnt_r[TW-1:0] : '0;
        ls_we    = (cnt_r != '0);
        if (cnt_r == CNT_END) begin
          fs_we         = 1'b1;
          fs_waddr      = '0;
          fs_vld_nxt[0] = 1'b1;
          top_nxt       = '0;
          if (total_r < TOT_MAX) begin
            total_nxt = total_r + TOT_W'(1);
          end
          fin = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_REFILL: begin
        if (cnt_r != '0) begin
          fs_we    = 1'b1;
          fs_waddr = cnt_m1[TW-1:0];
          fs_wdata = ls_rdata;
          fs_vld_nxt[cnt_m1[TW-1:0]] = 1'b1;
        end
        if (cnt_r == CNT_END) begin
          top_nxt   = TOP_LAST;
          total_nxt = total_r - TOT_W'(1);
          fin       = 1'b1;
          fin_blk   = res_blk_r;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_HOLD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      hold_blk_nxt    = fin_blk;
      hold_status_nxt = fin_status;
      state_nxt       = slot_free ? ST_IDLE : ST_HOLD;
    end
  end

  // Output register: loads a finished result or the held one when free.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_blk_nxt    = out_blk_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    if (slot_free) begin
      if (fin) begin
        out_valid_nxt  = 1'b1;
        out_blk_nxt    = fin_blk;
        out_status_nxt = fin_status;
        out_cnt_nxt    = total_ext[CNT_W-1:0];
      end else if (state_r == ST_HOLD) begin
        out_valid_nxt  = 1'b1;
        out_blk_nxt    = hold_blk_r;
        out_status_nxt = hold_status_r;
        out_cnt_nxt    = total_ext[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      fs_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      fs_vld_r    <= fs_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_command;
      blk_r <= in_block_in;
    end
    grp_r         <= grp_nxt;
    res_blk_r     <= res_blk_nxt;
    hold_blk_r    <= hold_blk_nxt;
    hold_status_r <= hold_status_nxt;
    rd_vld_r      <= fs_vld_r[fs_raddr];
    out_blk_r     <= out_blk_nxt;
    out_status_r  <= out_status_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_block_out  = out_blk_r;
  assign out_status     = out_status_r;
  assign out_free_count = out_cnt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gfba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
